>>> src/delta_inverse_kinematics_assert.svh
// Assertion macros shared by the checker files of the delta kinematics block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef DELTA_INVERSE_KINEMATICS_ASSERT_SVH
`define DELTA_INVERSE_KINEMATICS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DIK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dik_pkg.sv
// Package of the delta inverse kinematics block: widths, coefficients, codes.
// Used by the top level, the square root unit and the checker.
package dik_pkg;

	// Field and port widths.
	localparam int POS_W     = 27;
	localparam int HEIGHT_W  = 27;
	localparam int CFG_W     = 26;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 88;

	// Q0.30 coefficients and the shift that sets the rounding offset of a coefficient product.
	localparam int COEF_SHIFT = 30;
	localparam logic [29:0] SIN60_Q30 = 30'd929887697;
	localparam logic [29:0] SIN15_Q30 = 30'd277904785;

	// Register reset values.
	localparam logic [CFG_W-1:0] ARM_RADIUS_RST = 26'd7143424;
	localparam logic [CFG_W-1:0] ARM_LENGTH_RST = 26'd14240973;

	// Square root unit: radicand below 2^52, one result bit per step.
	localparam int RAD_W      = 52;
	localparam int ROOT_W     = 26;
	localparam int SQRT_CNT_W = 5;
	localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = 5'd25;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ARM_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_LENGTH = 2'd1;

	// Tower currently being solved.
	typedef enum logic [1:0] {
		TWR_A = 2'd0,
		TWR_B = 2'd1,
		TWR_C = 2'd2
	} tower_t;

	// Sequencer states.
	typedef enum logic [12:0] {
		ST_IDLE      = 13'b0000000000001,
		ST_SCALE_SX  = 13'b0000000000010,
		ST_SCALE_MIN = 13'b0000000000100,
		ST_LEN_SQ    = 13'b0000000001000,
		ST_MIN_SQ    = 13'b0000000010000,
		ST_DIFF      = 13'b0000000100000,
		ST_SQ_X      = 13'b0000001000000,
		ST_SQ_Y      = 13'b0000010000000,
		ST_DIST      = 13'b0000100000000,
		ST_TEST      = 13'b0001000000000,
		ST_ROOT_WAIT = 13'b0010000000000,
		ST_UPDATE    = 13'b0100000000000,
		ST_DONE      = 13'b1000000000000
	} state_t;

endpackage

>>> src/dik_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle (floor).
// Depends on dik_pkg for its widths and step count.
module dik_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dik_pkg::RAD_W-1:0]  radicand,
	output logic                       busy,
	output logic [dik_pkg::ROOT_W-1:0] root
);

	logic [dik_pkg::RAD_W-1:0]      rad_q;
	logic [dik_pkg::ROOT_W+1:0]     rem_q;
	logic [dik_pkg::ROOT_W-1:0]     root_q;
	logic [dik_pkg::SQRT_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic [dik_pkg::ROOT_W+3:0]     rem_sh;
	logic [dik_pkg::ROOT_W+3:0]     trial;
	logic [dik_pkg::ROOT_W+3:0]     diff;
	logic                           fits;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		rem_sh = {rem_q, rad_q[dik_pkg::RAD_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		diff   = rem_sh - trial;
		fits   = (rem_sh >= trial);
	end

	// Control: step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == dik_pkg::SQRT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder, partial root and the shifting radicand.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[dik_pkg::RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= diff[dik_pkg::ROOT_W+1:0];
				root_q <= {root_q[dik_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[dik_pkg::ROOT_W+1:0];
				root_q <= {root_q[dik_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

>>> src/delta_inverse_kinematics.sv
// Top level of the delta inverse kinematics block: sequencer, shared multiplier, held heights.
// Depends on dik_pkg and dik_isqrt.
//
//   channel  | direction | contents (lowest bit first)
//   s_*      | in        | x_pos[26:0], y_pos[53:27], z_pos[80:54], zeros to bit 87
//   m_*      | out       | height_a, height_b, height_c, reached_a..c[83:81], zeros
//   cfg_*    | in        | write of arm_radius (index 0) or arm_length (index 1)
//
// An item runs from acceptance through the setup states (coefficient scaling and squaring),
// then, per tower, the offset, square, distance and test states, and for a tower that
// reaches the square root its 26 serial steps and the update; the result is then loaded
// in the output register, later while a previous result still waits in the output register.
// s_tready is high only while the sequencer is idle; one result may wait in the output
// register while the next item is taken. Reset clears the held heights to zero and loads
// the register defaults.
module delta_inverse_kinematics (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dik_pkg::S_TDATA_W-1:0] s_tdata,  // x_pos, y_pos, z_pos
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dik_pkg::M_TDATA_W-1:0] m_tdata,  // height_a, height_b, height_c,
	                                                // reached_a, reached_b, reached_c
	input  logic                          cfg_we,
	input  logic [dik_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dik_pkg::CFG_W-1:0]     cfg_data
);

	localparam int PW = dik_pkg::POS_W;
	localparam int HW = dik_pkg::HEIGHT_W;
	localparam int CW = dik_pkg::CFG_W;

	dik_pkg::state_t state_q, state_d;
	dik_pkg::tower_t tower_q;

	logic [CW-1:0]      arm_radius_q, arm_length_q;
	logic [PW-1:0]      x_q, y_q, z_q;
	logic [63:0]        prod_q;
	logic [31:0]        mul_a, mul_b;
	logic [CW-1:0]      sx_q, minh_q;
	logic [51:0]        lensq_q, minsq_q;
	logic [PW-1:0]      mx_q, my_q;
	logic [53:0]        hx_q;
	logic signed [56:0] d_q;
	logic [HW-1:0]      held_q [3];
	logic [2:0]         reach_q;
	logic               m_tvalid_q;
	logic [HW-1:0]      out_a_q, out_b_q, out_c_q;
	logic [2:0]         out_reach_q;

	logic [56:0]        rnd_sum;
	logic [CW:0]        half_sum;
	logic [CW-1:0]      half;
	logic signed [27:0] tx, ty;
	logic signed [28:0] dx_p, dx_n, dy_p, dy_n;
	logic signed [56:0] d_next;
	logic signed [27:0] cand;
	logic               cand_pos;
	logic               reach_ok;
	logic               last_tower;
	logic               sq_start;
	logic               sq_busy;
	logic [dik_pkg::ROOT_W-1:0] sq_root;
	logic               s_fire;
	logic               out_free;

	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == dik_pkg::ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_radius_q <= dik_pkg::ARM_RADIUS_RST;
			arm_length_q <= dik_pkg::ARM_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dik_pkg::REG_ARM_RADIUS: arm_radius_q <= cfg_data;
				dik_pkg::REG_ARM_LENGTH: arm_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier: operands chosen by the sequencer, product always registered.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			dik_pkg::ST_SCALE_SX: begin
				mul_a = {6'b0, arm_radius_q};
				mul_b = {2'b0, dik_pkg::SIN60_Q30};
			end
			dik_pkg::ST_SCALE_MIN: begin
				mul_a = {6'b0, arm_length_q};
				mul_b = {2'b0, dik_pkg::SIN15_Q30};
			end
			dik_pkg::ST_LEN_SQ: begin
				mul_a = {6'b0, arm_length_q};
				mul_b = {6'b0, arm_length_q};
			end
			dik_pkg::ST_MIN_SQ: begin
				mul_a = {6'b0, minh_q};
				mul_b = {6'b0, minh_q};
			end
			dik_pkg::ST_SQ_X: begin
				mul_a = {5'b0, mx_q};
				mul_b = {5'b0, mx_q};
			end
			dik_pkg::ST_SQ_Y: begin
				mul_a = {5'b0, my_q};
				mul_b = {5'b0, my_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Coefficient product rounded to nearest, ties up.
	assign rnd_sum = prod_q[56:0] + (57'd1 << (dik_pkg::COEF_SHIFT - 1));

	// Tower coordinates of the current tower.
	always_comb begin
		half_sum = {1'b0, arm_radius_q} + 27'd1;
		half     = half_sum[CW:1];
		tx       = '0;
		ty       = '0;
		unique case (tower_q)
			dik_pkg::TWR_A: begin
				tx = -$signed({2'b00, sx_q});
				ty = -$signed({2'b00, half});
			end
			dik_pkg::TWR_B: begin
				tx = $signed({2'b00, sx_q});
				ty = -$signed({2'b00, half});
			end
			dik_pkg::TWR_C: begin
				tx = '0;
				ty = $signed({2'b00, arm_radius_q});
			end
			default: ;
		endcase
	end

	// Offsets from tower to target, both directions so the magnitude is a selection.
	always_comb begin
		dx_p = 29'(tx) - 29'($signed(x_q));
		dx_n = 29'($signed(x_q)) - 29'(tx);
		dy_p = 29'(ty) - 29'($signed(y_q));
		dy_n = 29'($signed(y_q)) - 29'(ty);
	end

	// Remaining vertical reach squared and the candidate height.
	always_comb begin
		d_next   = $signed({5'b0, lensq_q}) - $signed({3'b0, hx_q})
		         - $signed({3'b0, prod_q[53:0]});
		cand     = $signed({2'b00, sq_root}) + $signed({z_q[PW-1], z_q});
		cand_pos = !cand[27] && (cand != '0);
		reach_ok = (d_q > $signed({5'b0, minsq_q}));
		last_tower = (tower_q == dik_pkg::TWR_C);
	end

	assign sq_start = (state_q == dik_pkg::ST_TEST) && reach_ok;

	dik_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (d_q[dik_pkg::RAD_W-1:0]),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dik_pkg::ST_IDLE:      if (s_fire) state_d = dik_pkg::ST_SCALE_SX;
			dik_pkg::ST_SCALE_SX:  state_d = dik_pkg::ST_SCALE_MIN;
			dik_pkg::ST_SCALE_MIN: state_d = dik_pkg::ST_LEN_SQ;
			dik_pkg::ST_LEN_SQ:    state_d = dik_pkg::ST_MIN_SQ;
			dik_pkg::ST_MIN_SQ:    state_d = dik_pkg::ST_DIFF;
			dik_pkg::ST_DIFF:      state_d = dik_pkg::ST_SQ_X;
			dik_pkg::ST_SQ_X:      state_d = dik_pkg::ST_SQ_Y;
			dik_pkg::ST_SQ_Y:      state_d = dik_pkg::ST_DIST;
			dik_pkg::ST_DIST:      state_d = dik_pkg::ST_TEST;
			dik_pkg::ST_TEST: begin
				if (reach_ok) begin
					state_d = dik_pkg::ST_ROOT_WAIT;
				end else if (last_tower) begin
					state_d = dik_pkg::ST_DONE;
				end else begin
					state_d = dik_pkg::ST_DIFF;
				end
			end
			dik_pkg::ST_ROOT_WAIT: if (!sq_busy) state_d = dik_pkg::ST_UPDATE;
			dik_pkg::ST_UPDATE: begin
				state_d = last_tower ? dik_pkg::ST_DONE : dik_pkg::ST_DIFF;
			end
			dik_pkg::ST_DONE:      if (out_free) state_d = dik_pkg::ST_IDLE;
			default:               state_d = dik_pkg::ST_IDLE;
		endcase
	end

	// Control state: sequencer, tower index, reached flags, held heights, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dik_pkg::ST_IDLE;
			tower_q    <= dik_pkg::TWR_A;
			reach_q    <= '0;
			held_q[0]  <= '0;
			held_q[1]  <= '0;
			held_q[2]  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == dik_pkg::ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				dik_pkg::ST_IDLE: begin
					if (s_fire) begin
						tower_q <= dik_pkg::TWR_A;
						reach_q <= '0;
					end
				end
				dik_pkg::ST_TEST: begin
					if (!reach_ok && !last_tower) begin
						tower_q <= dik_pkg::tower_t'(tower_q + 2'd1);
					end
				end
				dik_pkg::ST_UPDATE: begin
					if (cand_pos) begin
						held_q[tower_q] <= cand[HW-1:0];
						reach_q[tower_q] <= 1'b1;
					end
					if (!last_tower) begin
						tower_q <= dik_pkg::tower_t'(tower_q + 2'd1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers of one item.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			x_q <= s_tdata[PW-1:0];
			y_q <= s_tdata[2*PW-1:PW];
			z_q <= s_tdata[3*PW-1:2*PW];
		end
		case (state_q)
			dik_pkg::ST_SCALE_MIN: sx_q    <= rnd_sum[55:30];
			dik_pkg::ST_LEN_SQ:    minh_q  <= rnd_sum[55:30];
			dik_pkg::ST_MIN_SQ:    lensq_q <= prod_q[51:0];
			dik_pkg::ST_DIFF: begin
				if (tower_q == dik_pkg::TWR_A) begin
					minsq_q <= prod_q[51:0];
				end
				mx_q <= dx_p[28] ? dx_n[PW-1:0] : dx_p[PW-1:0];
				my_q <= dy_p[28] ? dy_n[PW-1:0] : dy_p[PW-1:0];
			end
			dik_pkg::ST_SQ_Y:      hx_q <= prod_q[53:0];
			dik_pkg::ST_DIST:      d_q  <= d_next;
			default: ;
		endcase
	end

	// Output register, loaded once the previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_a_q     <= '0;
			out_b_q     <= '0;
			out_c_q     <= '0;
			out_reach_q <= '0;
		end else if ((state_q == dik_pkg::ST_DONE) && out_free) begin
			out_a_q     <= held_q[0];
			out_b_q     <= held_q[1];
			out_c_q     <= held_q[2];
			out_reach_q <= reach_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_reach_q, out_c_q, out_b_q, out_a_q};

endmodule

>>> src/dik_checker.sv
// Port-level checker of the delta inverse kinematics block, bound to the top level.
// Depends on dik_pkg and the macros in delta_inverse_kinematics_assert.svh.
`include "delta_inverse_kinematics_assert.svh"

module dik_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dik_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int HW = dik_pkg::HEIGHT_W;

	logic                          s_fire;
	logic                          out_stall;
	logic [HW-1:0]                 height_a, height_b, height_c;
	logic [2:0]                    reached;
	logic [2:0]                    zero_reached;
	logic [2:0]                    height_kept;
	logic [dik_pkg::M_TDATA_W-1:0] m_tdata_q;

	// Result fields, lowest first.
	assign height_a = m_tdata[HW-1:0];
	assign height_b = m_tdata[2*HW-1:HW];
	assign height_c = m_tdata[3*HW-1:2*HW];
	assign reached  = m_tdata[3*HW+2:3*HW];

	assign s_fire    = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;

	// Towers flagged as reached while showing a zero height.
	assign zero_reached = reached & {height_c == '0, height_b == '0, height_a == '0};

	// Result seen at the previous edge, to compare held heights against.
	always_ff @(posedge clk) begin
		m_tdata_q <= m_tdata;
	end

	assign height_kept = {height_c == m_tdata_q[3*HW-1:2*HW],
	                      height_b == m_tdata_q[2*HW-1:HW],
	                      height_a == m_tdata_q[HW-1:0]};

	// An accepted item keeps the block busy for the following cycle.
	`DIK_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_fire, !s_tready, "ready after accept")

	// A stalled result keeps its value.
	`DIK_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata), "result moved")

	// A tower marked as reached has a positive height.
	`DIK_ASSERT_IMP(a_reached_positive, clk, arst_n, m_tvalid, zero_reached == '0, "zero height")

	// A tower not reached keeps the height of the previous result.
	`DIK_ASSERT_IMP(a_held_kept, clk, arst_n, $rose(m_tvalid), &(reached | height_kept), "held moved")

endmodule

bind delta_inverse_kinematics dik_checker u_dik_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
